### rtl/core/circle_lattice_point_counter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circle lattice point counter
// Concurrent checks are written through these macros; they are empty in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_LATTICE_POINT_COUNTER_TOP_ASSERT_SVH
`define CIRCLE_LATTICE_POINT_COUNTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define CLPC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clpc: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define CLPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clpc: next-cycle check failed");

`else

`define CLPC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define CLPC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/clpc_pkg.sv
// ----------------------------------------------------------------------------
// clpc_pkg - shared types and constants of the lattice point counter
// Field widths, division constants and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package clpc_pkg;

  localparam int CX_W        = 31;
  localparam int R_W         = 27;
  localparam int CNT_W       = 29;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 32;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 64;
  localparam int SUM_W  = 34;
  localparam int SQ_W   = 54;
  localparam int ROOT_W = 27;
  localparam int Q_W    = 19;
  localparam int COL_W  = 15;
  localparam int DX_W   = 28;

  localparam logic [R_W-1:0]   RADIUS_MAX = 27'd100000000;
  localparam logic [MUL_W-1:0] UNIT_SCALE = 32'd10000;
  localparam logic [DX_W-1:0]  DX_STEP    = 28'd10000;
  // floor(u / 10000) == (u * DIV_MAGIC) >> DIV_SHIFT for every 32-bit u.
  localparam logic [MUL_W-1:0] DIV_MAGIC  = 32'd3518437209;
  localparam int               DIV_SHIFT  = 45;
  // 10000 * 2^18: lifts every signed dividend into the unsigned range.
  localparam logic [SUM_W-1:0] DIV_BIAS   = 34'd2621440000;
  localparam logic [SUM_W-1:0] CEIL_ADJ   = 34'd9999;
  localparam logic [SQ_W-1:0]  SQRT_BIT0  = {2'b01, {(SQ_W-2){1'b0}}};

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_RR    = 3'd1,
    OP_CLO   = 3'd2,
    OP_CHI   = 3'd3,
    OP_SCALE = 3'd4,
    OP_DXDX  = 3'd5,
    OP_RHI   = 3'd6,
    OP_RLO   = 3'd7
  } clpc_op_t;

  typedef struct packed {
    logic     load;
    clpc_op_t op;
    logic     cap_r2;
    logic     cap_qlo;
    logic     cap_ncol;
    logic     cap_dx;
    logic     sq_init;
    logic     sq_step;
    logic     cap_qhi;
    logic     row_acc;
    logic     col_step;
    logic     out_load;
  } clpc_cmd_t;

  typedef struct packed {
    logic ncol_zero;
    logic sq_neg;
    logic sq_last;
    logic col_last;
  } clpc_sts_t;

endpackage

### rtl/core/clpc_dp.sv
// ----------------------------------------------------------------------------
// clpc_dp - datapath of the lattice point counter
// Shared pipelined multiplier, bit-serial square root, column walk and the
// point count accumulator.
// ----------------------------------------------------------------------------
module clpc_dp
  import clpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [CX_W-1:0]  center_x,
  input  logic signed [CX_W-1:0]  center_y,
  input  logic        [R_W-1:0]   radius,
  input  clpc_cmd_t               cmd,
  output clpc_sts_t               sts,
  output logic        [CNT_W-1:0] point_count
);

  `include "circle_lattice_point_counter_top_assert.svh"

  logic [CX_W-1:0]   cx_r;
  logic [SUM_W-1:0]  cyb_r;
  logic [R_W-1:0]    r_r;
  logic [MUL_W-1:0]  a_r, a_nxt;
  logic [MUL_W-1:0]  b_r, b_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [SQ_W-1:0]   r2_r;
  logic [Q_W-1:0]    qlo_r;
  logic [Q_W-1:0]    qhi_r;
  logic [COL_W-1:0]  ncol_r;
  logic [DX_W-1:0]   dx_r;
  logic [SQ_W-1:0]   rem_r;
  logic [SQ_W-1:0]   root_r;
  logic [SQ_W-1:0]   bit_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  out_r;

  logic [R_W-1:0]    r_sat;
  logic [SUM_W-1:0]  cx_s, r_z, t_z;
  logic [SUM_W-1:0]  sum_clo, sum_chi, sum_rhi, sum_rlo, dx_full;
  logic [Q_W-1:0]    q_prod;
  logic [DX_W-1:0]   dx_neg;
  logic [R_W-1:0]    dx_abs;
  logic [SQ_W:0]     sq_diff;
  logic [SQ_W:0]     trial;
  logic              trial_ok;

  assign r_sat  = (radius > RADIUS_MAX) ? RADIUS_MAX : radius;
  assign cx_s   = {{(SUM_W-CX_W){cx_r[CX_W-1]}}, cx_r};
  assign r_z    = {{(SUM_W-R_W){1'b0}}, r_r};
  assign t_z    = {{(SUM_W-ROOT_W){1'b0}}, root_r[ROOT_W-1:0]};

  // Biased dividends; ceiling divisions add 9999 ahead of the floor.
  assign sum_clo = cx_s - r_z + CEIL_ADJ + DIV_BIAS;
  assign sum_chi = cx_s + r_z + DIV_BIAS;
  assign sum_rhi = cyb_r + t_z;
  assign sum_rlo = cyb_r + CEIL_ADJ - t_z;

  assign q_prod  = prod_r[PROD_W-1:DIV_SHIFT];
  assign dx_full = {{(SUM_W-MUL_W){1'b0}}, prod_r[MUL_W-1:0]} - DIV_BIAS - cx_s;
  assign dx_neg  = -dx_r;
  assign dx_abs  = dx_r[DX_W-1] ? dx_neg[R_W-1:0] : dx_r[R_W-1:0];

  assign sq_diff  = {1'b0, r2_r} - {1'b0, prod_r[SQ_W-1:0]};
  assign trial    = {1'b0, root_r} + {1'b0, bit_r};
  assign trial_ok = ({1'b0, rem_r} >= trial);

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    case (cmd.op)
      OP_RR: begin
        a_nxt = {{(MUL_W-R_W){1'b0}}, r_r};
        b_nxt = {{(MUL_W-R_W){1'b0}}, r_r};
      end
      OP_CLO: begin
        a_nxt = sum_clo[MUL_W-1:0];
        b_nxt = DIV_MAGIC;
      end
      OP_CHI: begin
        a_nxt = sum_chi[MUL_W-1:0];
        b_nxt = DIV_MAGIC;
      end
      OP_SCALE: begin
        a_nxt = {{(MUL_W-Q_W){1'b0}}, qlo_r};
        b_nxt = UNIT_SCALE;
      end
      OP_DXDX: begin
        a_nxt = {{(MUL_W-R_W){1'b0}}, dx_abs};
        b_nxt = {{(MUL_W-R_W){1'b0}}, dx_abs};
      end
      OP_RHI: begin
        a_nxt = sum_rhi[MUL_W-1:0];
        b_nxt = DIV_MAGIC;
      end
      OP_RLO: begin
        a_nxt = sum_rlo[MUL_W-1:0];
        b_nxt = DIV_MAGIC;
      end
      default: begin
        a_nxt = a_r;
        b_nxt = b_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= {{(PROD_W-MUL_W){1'b0}}, a_r} * {{(PROD_W-MUL_W){1'b0}}, b_r};

    if (cmd.load) begin
      cx_r    <= center_x;
      cyb_r   <= {{(SUM_W-CX_W){center_y[CX_W-1]}}, center_y} + DIV_BIAS;
      r_r     <= r_sat;
      count_r <= '0;
    end
    if (cmd.cap_r2) begin
      r2_r <= prod_r[SQ_W-1:0];
    end
    if (cmd.cap_qlo) begin
      qlo_r <= q_prod;
    end
    if (cmd.cap_ncol) begin
      if (q_prod >= qlo_r) begin
        ncol_r <= COL_W'(q_prod - qlo_r) + COL_W'(1);
      end else begin
        ncol_r <= '0;
      end
    end
    if (cmd.cap_dx) begin
      dx_r <= dx_full[DX_W-1:0];
    end
    if (cmd.sq_init) begin
      rem_r  <= sq_diff[SQ_W-1:0];
      root_r <= '0;
      bit_r  <= SQRT_BIT0;
    end
    if (cmd.sq_step) begin
      if (trial_ok) begin
        rem_r  <= rem_r - trial[SQ_W-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.cap_qhi) begin
      qhi_r <= q_prod;
    end
    if (cmd.row_acc && (qhi_r >= q_prod)) begin
      count_r <= count_r + CNT_W'(qhi_r - q_prod) + CNT_W'(1);
    end
    if (cmd.col_step) begin
      dx_r   <= dx_r + DX_STEP;
      ncol_r <= ncol_r - COL_W'(1);
    end
    if (cmd.out_load) begin
      out_r <= count_r;
    end
  end

  assign sts.ncol_zero = (ncol_r == '0);
  assign sts.sq_neg    = sq_diff[SQ_W];
  assign sts.sq_last   = bit_r[0];
  assign sts.col_last  = (ncol_r == COL_W'(1));
  assign point_count   = out_r;

  `CLPC_ASSERT_IMPL(a_col_left, clk, rst_n, cmd.op == OP_DXDX, ncol_r != '0)
  `CLPC_ASSERT_IMPL(a_dx_in_circle, clk, rst_n, cmd.op == OP_DXDX, dx_abs <= r_r)
  `CLPC_ASSERT_IMPL(a_sqrt_bit, clk, rst_n, cmd.sq_step, $onehot(bit_r))
  `CLPC_ASSERT_NEXT(a_count_clear, clk, rst_n, cmd.load, count_r == '0)

endmodule

### rtl/core/clpc_ctrl.sv
// ----------------------------------------------------------------------------
// clpc_ctrl - sequencer of the lattice point counter
// One-hot state machine that issues datapath commands, walks the columns
// and owns both stream handshakes.
// ----------------------------------------------------------------------------
module clpc_ctrl
  import clpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  clpc_sts_t sts,
  output clpc_cmd_t cmd
);

  typedef enum logic [16:0] {
    ST_IDLE   = 17'h00001,
    ST_R2     = 17'h00002,
    ST_CLO    = 17'h00004,
    ST_CHI    = 17'h00008,
    ST_W1     = 17'h00010,
    ST_W2     = 17'h00020,
    ST_W3     = 17'h00040,
    ST_W4     = 17'h00080,
    ST_COL    = 17'h00100,
    ST_CW1    = 17'h00200,
    ST_CW2    = 17'h00400,
    ST_SQRT   = 17'h00800,
    ST_ROWS   = 17'h01000,
    ST_ROWL   = 17'h02000,
    ST_RW1    = 17'h04000,
    ST_RW2    = 17'h08000,
    ST_FINISH = 17'h10000
  } clpc_state_t;

  clpc_state_t state_r, state_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic        finish;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    finish    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_R2;
        end
      end
      ST_R2: begin
        cmd.op    = OP_RR;
        state_nxt = ST_CLO;
      end
      ST_CLO: begin
        cmd.op    = OP_CLO;
        state_nxt = ST_CHI;
      end
      ST_CHI: begin
        cmd.op     = OP_CHI;
        cmd.cap_r2 = 1'b1;
        state_nxt  = ST_W1;
      end
      ST_W1: begin
        cmd.cap_qlo = 1'b1;
        state_nxt   = ST_W2;
      end
      ST_W2: begin
        cmd.cap_ncol = 1'b1;
        cmd.op       = OP_SCALE;
        state_nxt    = ST_W3;
      end
      ST_W3: begin
        state_nxt = ST_W4;
      end
      ST_W4: begin
        cmd.cap_dx = 1'b1;
        state_nxt  = sts.ncol_zero ? ST_FINISH : ST_COL;
      end
      ST_COL: begin
        cmd.op    = OP_DXDX;
        state_nxt = ST_CW1;
      end
      ST_CW1: begin
        state_nxt = ST_CW2;
      end
      ST_CW2: begin
        if (sts.sq_neg) begin
          // Column lies outside the circle: it adds nothing.
          cmd.col_step = 1'b1;
          state_nxt    = sts.col_last ? ST_FINISH : ST_COL;
        end else begin
          cmd.sq_init = 1'b1;
          state_nxt   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sq_step = 1'b1;
        if (sts.sq_last) begin
          state_nxt = ST_ROWS;
        end
      end
      ST_ROWS: begin
        cmd.op    = OP_RHI;
        state_nxt = ST_ROWL;
      end
      ST_ROWL: begin
        cmd.op    = OP_RLO;
        state_nxt = ST_RW1;
      end
      ST_RW1: begin
        cmd.cap_qhi = 1'b1;
        state_nxt   = ST_RW2;
      end
      ST_RW2: begin
        cmd.row_acc  = 1'b1;
        cmd.col_step = 1'b1;
        state_nxt    = sts.col_last ? ST_FINISH : ST_COL;
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          finish       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid_nxt = finish | (out_tvalid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

### rtl/core/circle_lattice_point_counter_top.sv
// ----------------------------------------------------------------------------
// circle_lattice_point_counter_top - integer points inside a circle
// Counts the integer grid points inside or on a circle whose center and
// radius are given in fixed point scaled by 10000.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake           Contents of one request
//   in_       slave       in_tvalid/tready    center_x, center_y, radius
//   out_      master      out_tvalid/tready   point_count
//
// One circle is processed at a time. A request runs from acceptance to the
// result register through a setup phase and then one pass per integer
// column the circle spans (up to 20001 columns). Each column pass is set
// by the 27-step bit-serial square root plus the shared multiplier's
// operand and product registers for the squared offset and the two row
// divisions. Reset is synchronous and active low; it clears the
// sequencer and the result valid flag. A finished result waits in its output
// register, and the next circle is accepted while it waits; only the
// following result stalls until out_tready takes the pending one.
//
// Columns run from ceil((X-R)/10000) to floor((X+R)/10000). For every column
// the exact floor square root of R*R - dx*dx gives the half chord, and the
// rows between the ceiling and floor divisions of Y -/+ that half chord are
// added to the count. Divisions by 10000 are done as a multiply by a
// reciprocal on a biased, always positive dividend, so both signs of the
// center are handled without a divider. A radius above 100000000 is clamped
// to that value.
//
module circle_lattice_point_counter_top
  import clpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [30:0] center_x, [61:31] center_y, [88:62] radius, [95:89] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [28:0] point_count, [31:29] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  clpc_cmd_t         cmd;
  clpc_sts_t         sts;
  logic [CNT_W-1:0]  point_count;

  // The sequencer owns both handshakes; the datapath only follows commands.
  clpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Request fields are captured by the datapath on the accepting edge.
  clpc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .center_x    (in_tdata[CX_W-1:0]),
    .center_y    (in_tdata[2*CX_W-1:CX_W]),
    .radius      (in_tdata[2*CX_W+R_W-1:2*CX_W]),
    .cmd         (cmd),
    .sts         (sts),
    .point_count (point_count)
  );

  assign out_tdata = {{(OUT_TDATA_W-CNT_W){1'b0}}, point_count};

endmodule
